// File: hdl/hfr_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request framer package
// Shared widths, character codes and result tags for the framer and its
// stream interfaces.
// ----------------------------------------------------------------------------
package hfr_pkg;

    // Default width of offsets and lengths inside the framer
    localparam int DEF_LENGTH_BITS = 32;

    // Width of the reported lengths
    localparam int OUT_BITS = 32;
    localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

    // Byte tag carried with every result
    typedef logic [1:0] role_t;
    localparam role_t ROLE_OTHER  = 2'd0;
    localparam role_t ROLE_METHOD = 2'd1;
    localparam role_t ROLE_URL    = 2'd2;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Header name matcher: index into the name, and a sticky mismatch mark
    typedef logic [4:0] match_t;
    localparam match_t NAME_LEN  = 5'd14;
    localparam match_t NAME_FAIL = 5'd31;

    // Characters of the header name that carries the body length
    function automatic logic [7:0] hdr_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/hfr_byte_if.sv
// ----------------------------------------------------------------------------
// HTTP request framer byte stream
// Valid/ready channel carrying one request byte and its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface hfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hdl/hfr_result_if.sv
// ----------------------------------------------------------------------------
// HTTP request framer result stream
// Valid/ready channel carrying the tag of each byte and the framing verdict.
// ----------------------------------------------------------------------------
interface hfr_result_if;
    logic                          valid;
    logic                          ready;
    hfr_pkg::role_t                byte_role;
    logic                          done_res;
    logic                          complete;
    logic [hfr_pkg::OUT_BITS-1:0]  frame_length;
    logic [hfr_pkg::OUT_BITS-1:0]  content_length;

    modport source (output valid, output byte_role, output done_res, output complete,
                    output frame_length, output content_length, input ready);
    modport sink   (input valid, input byte_role, input done_res, input complete,
                    input frame_length, input content_length, output ready);
endinterface

// File: hdl/http_request_framer.sv
// ----------------------------------------------------------------------------
// HTTP request framer
// Scans a buffered HTTP/1.1 request byte by byte, tags method and URL bytes,
// picks out the Content-Length header and reports whether the request is
// complete when the last byte arrives.
// ----------------------------------------------------------------------------
// The framer takes one request byte per clock, unless a held result is not yet
// taken, and returns one registered result per byte; it keeps this rate for any
// length of buffer, limited only by the combinational parse step (line tracking,
// header name match and one decimal digit of the length value) that sits in
// front of the result register. The result for the byte marked last carries
// done_res, the completeness verdict, the frame length and the content length;
// all other results carry zero there. After the last byte the framer is back
// in its reset state and the next byte starts a new request. Offsets and
// lengths are LENGTH_BITS wide and saturate; the reported lengths saturate at
// 32 bits. No clearing pass is needed after reset.
module http_request_framer #(
    parameter int LENGTH_BITS = hfr_pkg::DEF_LENGTH_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    hfr_byte_if.sink     bytes,
    hfr_result_if.source results
);

    localparam int LB = LENGTH_BITS;
    localparam int WB = (LB > hfr_pkg::OUT_BITS) ? LB : hfr_pkg::OUT_BITS;
    localparam logic [LB-1:0] LMAX = {LB{1'b1}};

    // Request line and header phases
    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_GAP     = 3'd1;
    localparam logic [2:0] PH_URL     = 3'd2;
    localparam logic [2:0] PH_REST    = 3'd3;
    localparam logic [2:0] PH_HEADERS = 3'd4;
    localparam logic [2:0] PH_BODY    = 3'd5;

    // Length value parse states
    localparam logic [1:0] VS_SKIP = 2'd0;
    localparam logic [1:0] VS_POS  = 2'd1;
    localparam logic [1:0] VS_NEG  = 2'd2;
    localparam logic [1:0] VS_STOP = 2'd3;

    // Per-line parse state
    typedef struct packed {
        logic [2:0]      phase;
        hfr_pkg::match_t match;
        logic            colon;
        logic [1:0]      vst;
        logic [LB-1:0]   acc;
    } line_t;

    // Saturating add of two lengths
    function automatic logic [LB-1:0] sat_add(input logic [LB-1:0] a, input logic [LB-1:0] b);
        logic [LB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LB] ? LMAX : s[LB-1:0];
    endfunction

    // Clip a length to the reported width
    function automatic logic [hfr_pkg::OUT_BITS-1:0] clip_out(input logic [LB-1:0] v);
        logic [WB-1:0] e;
        e = WB'(v);
        if (e > WB'(hfr_pkg::OUT_MAX))
            return hfr_pkg::OUT_MAX;
        return e[hfr_pkg::OUT_BITS-1:0];
    endfunction

    // Tag of a byte fed on the request line
    function automatic hfr_pkg::role_t role_of(input logic [2:0] ph, input logic [7:0] c);
        hfr_pkg::role_t r;
        case (ph)
            PH_METHOD: r = (c == hfr_pkg::CH_SP) ? hfr_pkg::ROLE_OTHER : hfr_pkg::ROLE_METHOD;
            PH_GAP:    r = (c == hfr_pkg::CH_SP) ? hfr_pkg::ROLE_OTHER : hfr_pkg::ROLE_URL;
            PH_URL:    r = (c == hfr_pkg::CH_SP) ? hfr_pkg::ROLE_OTHER : hfr_pkg::ROLE_URL;
            default:   r = hfr_pkg::ROLE_OTHER;
        endcase
        return r;
    endfunction

    // Advance the line state by one ordinary byte
    function automatic line_t line_feed(input line_t s, input logic [7:0] c);
        line_t         n;
        logic [LB+3:0] prod;
        logic          digit;
        logic          blank;
        n     = s;
        digit = (c >= hfr_pkg::CH_ZERO) && (c <= hfr_pkg::CH_NINE);
        blank = (c == hfr_pkg::CH_SP) || ((c >= hfr_pkg::CH_TAB) && (c <= hfr_pkg::CH_CR));
        prod  = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + (LB+4)'(c[3:0]);
        case (s.phase)
            PH_METHOD: if (c == hfr_pkg::CH_SP) n.phase = PH_GAP;
            PH_GAP:    if (c != hfr_pkg::CH_SP) n.phase = PH_URL;
            PH_URL:    if (c == hfr_pkg::CH_SP) n.phase = PH_REST;
            PH_REST:   n.phase = PH_REST;
            default:
            begin
                if (!s.colon)
                begin
                    // match the header name up to the first colon
                    if (c == hfr_pkg::CH_COLON)
                        n.colon = 1'b1;
                    else if (s.match < hfr_pkg::NAME_LEN && c == hfr_pkg::hdr_char(s.match[3:0]))
                        n.match = s.match + 5'd1;
                    else
                        n.match = hfr_pkg::NAME_FAIL;
                end
                else if (s.match == hfr_pkg::NAME_LEN && s.vst != VS_STOP)
                begin
                    // parse the length value: blanks, sign, digits
                    if (digit)
                    begin
                        if (s.vst == VS_SKIP)
                            n.vst = VS_POS;
                        n.acc = (prod > (LB+4)'(LMAX)) ? LMAX : prod[LB-1:0];
                    end
                    else if (s.vst == VS_SKIP)
                    begin
                        if (blank)
                            n.vst = VS_SKIP;
                        else if (c == hfr_pkg::CH_PLUS)
                            n.vst = VS_POS;
                        else if (c == hfr_pkg::CH_MINUS)
                            n.vst = VS_NEG;
                        else
                            n.vst = VS_STOP;
                    end
                    else
                    begin
                        if (s.vst == VS_NEG && s.acc != '0)
                            n.acc = LMAX;
                        n.vst = VS_STOP;
                    end
                end
            end
        endcase
        return n;
    endfunction

    // State registers
    line_t         line_reg, line_next;
    logic [LB-1:0] byte_offset_reg, byte_offset_next;
    logic [LB-1:0] line_start_reg, line_start_next;
    logic [LB-1:0] reached_reg, reached_next;
    logic [LB-1:0] body_length_reg, body_length_next;
    logic          prev_cr_reg, prev_cr_next;
    logic          line_bad_reg, line_bad_next;

    // Result registers
    logic                         out_valid_reg;
    hfr_pkg::role_t               role_reg, role_next;
    logic                         done_reg, done_next;
    logic                         complete_reg, complete_next;
    logic [hfr_pkg::OUT_BITS-1:0] frame_reg, frame_next;
    logic [hfr_pkg::OUT_BITS-1:0] content_reg, content_next;

    logic          in_fire;
    line_t         fed_cr;
    line_t         fed_byte;
    logic [LB-1:0] total;
    logic [LB-1:0] final_reached;
    logic [LB-1:0] body_present;

    assign bytes.ready = !out_valid_reg || results.ready;
    assign in_fire     = bytes.valid && bytes.ready;

    // Feed a pending CR that did not start a line break, then the new byte
    assign fed_cr   = prev_cr_reg ? line_feed(line_reg, hfr_pkg::CH_CR) : line_reg;
    assign fed_byte = line_feed(fed_cr, bytes.data_byte);
    assign total    = (byte_offset_reg == LMAX) ? LMAX : byte_offset_reg + LB'(1);

    // Parse one byte and form its result
    always_comb
    begin
        line_next        = line_reg;
        line_start_next  = line_start_reg;
        reached_next     = reached_reg;
        body_length_next = body_length_reg;
        prev_cr_next     = prev_cr_reg;
        line_bad_next    = line_bad_reg;
        byte_offset_next = total;
        role_next        = hfr_pkg::ROLE_OTHER;
        final_reached    = reached_reg;
        body_present     = '0;

        if (!line_bad_reg && line_reg.phase != PH_BODY)
        begin
            if (prev_cr_reg && bytes.data_byte == hfr_pkg::CH_LF)
            begin
                // end of line
                prev_cr_next = 1'b0;
                if (line_reg.phase <= PH_REST)
                begin
                    if (line_reg.phase == PH_URL || line_reg.phase == PH_REST)
                    begin
                        line_next.phase = PH_HEADERS;
                        line_start_next = total;
                    end
                    else
                    begin
                        line_bad_next = 1'b1;
                        reached_next  = byte_offset_reg - LB'(1);
                    end
                end
                else
                begin
                    if (line_reg.colon)
                    begin
                        if (line_reg.match == hfr_pkg::NAME_LEN)
                            body_length_next = (line_reg.vst == VS_NEG && line_reg.acc != '0)
                                             ? LMAX : line_reg.acc;
                    end
                    else
                        line_next.phase = PH_BODY;
                    line_start_next = total;
                end
                line_next.match = '0;
                line_next.colon = 1'b0;
                line_next.vst   = VS_SKIP;
                line_next.acc   = '0;
            end
            else if (bytes.data_byte == hfr_pkg::CH_CR)
            begin
                // hold the CR until the next byte tells whether a break follows
                prev_cr_next = 1'b1;
                line_next    = fed_cr;
            end
            else
            begin
                prev_cr_next = 1'b0;
                line_next    = fed_byte;
                role_next    = role_of(fed_cr.phase, bytes.data_byte);
            end
        end

        // verdict on the last byte
        done_next     = bytes.last_byte;
        complete_next = 1'b0;
        frame_next    = '0;
        content_next  = '0;
        if (!line_bad_next)
            final_reached = (line_next.phase <= PH_REST) ? total : line_start_next;
        else
            final_reached = reached_next;
        body_present = total - final_reached;
        if (bytes.last_byte)
        begin
            complete_next = !line_bad_next && line_next.phase == PH_BODY
                          && (body_length_next == '0 || body_present >= body_length_next);
            frame_next    = clip_out(sat_add(final_reached, body_length_next));
            content_next  = clip_out(body_length_next);
        end
    end

    // Update parse state; return to reset after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg        <= '{phase: PH_METHOD, match: '0, colon: 1'b0,
                                 vst: VS_SKIP, acc: '0};
            byte_offset_reg <= '0;
            line_start_reg  <= '0;
            reached_reg     <= '0;
            body_length_reg <= '0;
            prev_cr_reg     <= 1'b0;
            line_bad_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            if (bytes.last_byte)
            begin
                line_reg        <= '{phase: PH_METHOD, match: '0, colon: 1'b0,
                                     vst: VS_SKIP, acc: '0};
                byte_offset_reg <= '0;
                line_start_reg  <= '0;
                reached_reg     <= '0;
                body_length_reg <= '0;
                prev_cr_reg     <= 1'b0;
                line_bad_reg    <= 1'b0;
            end
            else
            begin
                line_reg        <= line_next;
                byte_offset_reg <= byte_offset_next;
                line_start_reg  <= line_start_next;
                reached_reg     <= reached_next;
                body_length_reg <= body_length_next;
                prev_cr_reg     <= prev_cr_next;
                line_bad_reg    <= line_bad_next;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            role_reg     <= role_next;
            done_reg     <= done_next;
            complete_reg <= complete_next;
            frame_reg    <= frame_next;
            content_reg  <= content_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.byte_role      = role_reg;
    assign results.done_res       = done_reg;
    assign results.complete       = complete_reg;
    assign results.frame_length   = frame_reg;
    assign results.content_length = content_reg;

    // Only the last result of a request carries lengths and a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.done_res
        |-> !results.complete && results.frame_length == '0 && results.content_length == '0)
        else $error("framing fields set on a result that is not the last");

    // A complete request ends in its body, never on a tagged byte
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.complete
        |-> results.done_res && results.byte_role == hfr_pkg::ROLE_OTHER)
        else $error("complete flagged on a tagged or non-final byte");

    // The frame always covers the body length
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.frame_length >= results.content_length)
        else $error("frame length below content length");

    // A rejected request line freezes the parser on the request line
    assert property (@(posedge clk) disable iff (!rst_n)
        line_bad_reg |-> !prev_cr_reg && line_reg.phase <= PH_REST)
        else $error("parser moved on after a rejected request line");

    // The last byte returns the parser to its start
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && bytes.last_byte
        |=> byte_offset_reg == '0 && line_reg.phase == PH_METHOD && !line_bad_reg)
        else $error("parser not restarted after the last byte");

endmodule
